[src/utcl_pkg.sv]
package utcl_pkg;

  // CORDIC sizing: Q2.30 vector with headroom, angle in 2^24 units per turn
  localparam int unsigned RotIters = 18;
  localparam int unsigned IterW    = 5;
  localparam int unsigned XyW      = 35;
  localparam int unsigned ZW       = 25;
  localparam int unsigned CsW      = 19;

  // configuration port
  localparam int unsigned GainW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_POSITION_GAIN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADING_GAIN  = 2'd1;
  localparam logic [GainW-1:0]   POS_GAIN_RST      = 24'd65536;
  localparam logic [GainW-1:0]   HEAD_GAIN_RST     = 24'd131072;

  // job queue depth
  localparam int unsigned QDepth = 2;

  localparam logic signed [XyW-1:0] CORDIC_X0  = 35'sd652032874;
  localparam logic signed [27:0]    TWO_PI_Q24 = 28'sd105414357;

  // arctangent of 2^-i in 2^24 units per turn
  function automatic logic signed [ZW-1:0] atan_lut(input logic [IterW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:    r = 25'sd2097152;
      5'd1:    r = 25'sd1238021;
      5'd2:    r = 25'sd654136;
      5'd3:    r = 25'sd332050;
      5'd4:    r = 25'sd166669;
      5'd5:    r = 25'sd83416;
      5'd6:    r = 25'sd41718;
      5'd7:    r = 25'sd20860;
      5'd8:    r = 25'sd10430;
      5'd9:    r = 25'sd5215;
      5'd10:   r = 25'sd2608;
      5'd11:   r = 25'sd1304;
      5'd12:   r = 25'sd652;
      5'd13:   r = 25'sd326;
      5'd14:   r = 25'sd163;
      5'd15:   r = 25'sd81;
      5'd16:   r = 25'sd41;
      5'd17:   r = 25'sd20;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [32:0]   ex;
    logic signed [32:0]   ey;
    logic signed [ZW-1:0] z0;
    logic                 flip;
    logic signed [15:0]   herr;
    logic signed [31:0]   ff_speed;
    logic signed [31:0]   ff_turn;
  } job_t;

  typedef struct packed {
    logic [GainW-1:0] position_gain;
    logic [GainW-1:0] heading_gain;
  } cfg_t;

endpackage

[src/utcl_if.sv]
interface utcl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic        [15:0] robot_heading;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic        [15:0] target_heading;
  logic signed [31:0] feedforward_speed;
  logic signed [31:0] feedforward_turn;

  modport source (
    output valid, robot_x, robot_y, robot_heading, target_x, target_y,
           target_heading, feedforward_speed, feedforward_turn,
    input  ready
  );
  modport sink (
    input  valid, robot_x, robot_y, robot_heading, target_x, target_y,
           target_heading, feedforward_speed, feedforward_turn,
    output ready
  );
endinterface

interface utcl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed_command;
  logic signed [31:0] turn_command;
  logic               clipped;

  modport source (output valid, speed_command, turn_command, clipped, input ready);
  modport sink   (input valid, speed_command, turn_command, clipped, output ready);
endinterface

[src/unicycle_tracking_control_law_top.sv]
// Channel    Direction  Handshake      Payload
// in_if      input      valid / ready  measured pose, reference pose, feedforward speeds
// out_if     output     valid / ready  speed_command, turn_command, clipped
// cfg        input      cfg_we_i       cfg_idx_i selects gain, cfg_wdata_i 24 bit
//
// Each transaction passes through the back end in order: one load, 18 CORDIC
// iterations on the shared rotator, three multiply steps and one output load.
// The rotator sets the sustained rate; the front end and two-entry queue keep
// taking transactions while it works.
// Reset restores both gains and empties the queue and output register.
// A stalled output holds the back end in its output step; the queue then fills.
module unicycle_tracking_control_law_top
  import utcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_wdata_i,
  utcl_in_if.sink            in_if,
  utcl_out_if.source         out_if
);

  cfg_t cfg_q;
  job_t push_job, pop_job;
  logic push, pop, full, avail;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.position_gain <= POS_GAIN_RST;
      cfg_q.heading_gain  <= HEAD_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POSITION_GAIN: cfg_q.position_gain <= cfg_wdata_i;
        REG_HEADING_GAIN:  cfg_q.heading_gain  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  utcl_front u_front (
    .in_if    (in_if),
    .q_full_i (full),
    .q_push_o (push),
    .q_job_o  (push_job)
  );

  utcl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .job_o   (pop_job)
  );

  utcl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_avail_i (avail),
    .q_job_i   (pop_job),
    .q_pop_o   (pop),
    .out_if    (out_if)
  );

endmodule

[src/utcl_front.sv]
module utcl_front
  import utcl_pkg::*;
(
  utcl_in_if.sink in_if,
  input  logic    q_full_i,
  output logic    q_push_o,
  output job_t    q_job_o
);

  logic signed [15:0] hs;
  logic signed [15:0] ang;
  logic               far;

  // fold the heading into the right half-plane, remember to negate later
  assign hs  = $signed(in_if.robot_heading);
  assign far = (hs > 16'sd16384) || (hs < -16'sd16384);
  assign ang = far ? (hs ^ 16'sh8000) : hs;

  assign in_if.ready = !q_full_i;
  assign q_push_o    = in_if.valid && !q_full_i;

  // form errors and the starting rotation angle
  always_comb begin
    q_job_o.ex       = {in_if.target_x[31], in_if.target_x}
                     - {in_if.robot_x[31], in_if.robot_x};
    q_job_o.ey       = {in_if.target_y[31], in_if.target_y}
                     - {in_if.robot_y[31], in_if.robot_y};
    q_job_o.z0       = {ang[15], ang, 8'b0};
    q_job_o.flip     = far;
    q_job_o.herr     = $signed(in_if.target_heading - in_if.robot_heading);
    q_job_o.ff_speed = in_if.feedforward_speed;
    q_job_o.ff_turn  = in_if.feedforward_turn;
  end

endmodule

[src/utcl_fifo.sv]
module utcl_fifo
  import utcl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output job_t job_o
);

  job_t       mem_q [QDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(QDepth));
  assign avail_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rptr_q];

  // store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count out of range");
`endif

endmodule

[src/utcl_back.sv]
module utcl_back
  import utcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_avail_i,
  input  job_t        q_job_i,
  output logic        q_pop_o,
  utcl_out_if.source  out_if
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROT   = 3'd1;
  localparam logic [2:0] ST_PROJ0 = 3'd2;
  localparam logic [2:0] ST_PROJ1 = 3'd3;
  localparam logic [2:0] ST_GAIN  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [IterW-1:0]     iter_q;
  logic signed [XyW-1:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ZW-1:0]  z_q, z_d;
  logic signed [32:0]   ex_q, ey_q;
  logic                 flip_q;
  logic signed [15:0]   herr_q;
  logic signed [31:0]   ffs_q, fft_q;
  logic signed [CsW-1:0] s_q, c_w, s_w, c_raw, s_raw;
  logic signed [XyW-1:0] xr, yr;
  logic signed [52:0]   p_q, pe;
  logic signed [51:0]   pc;
  logic signed [36:0]   proj;
  logic signed [52:0]   proj_full;
  logic signed [61:0]   g_q;
  logic signed [43:0]   hm_q;
  logic signed [27:0]   rad;
  logic signed [43:0]   rad_full;
  logic signed [52:0]   tm_q;
  logic signed [61:0]   g_rnd;
  logic signed [52:0]   tm_rnd;
  logic signed [46:0]   spd_sum;
  logic signed [32:0]   trn_sum;
  logic signed [31:0]   spd_sat, trn_sat;
  logic                 spd_hit, trn_hit;
  logic                 out_valid_q;
  logic signed [31:0]   spd_q, trn_q;
  logic                 clip_q;
  logic                 out_ld;

  // one CORDIC micro-rotation
  always_comb begin
    dx = y_q >>> iter_q;
    dy = x_q >>> iter_q;
    if (!z_q[ZW-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - atan_lut(iter_q);
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + atan_lut(iter_q);
    end
  end

  // round the vector to Q16 and undo the half-turn fold
  assign xr    = (x_q + 35'sd8192) >>> 14;
  assign yr    = (y_q + 35'sd8192) >>> 14;
  assign c_raw = $signed(xr[CsW-1:0]);
  assign s_raw = $signed(yr[CsW-1:0]);
  assign c_w   = flip_q ? -c_raw : c_raw;
  assign s_w   = flip_q ? -s_raw : s_raw;

  assign pc        = ex_q * c_w;
  assign pe        = ey_q * s_q;
  assign proj_full = (p_q + 53'sd32768) >>> 16;
  assign proj      = $signed(proj_full[36:0]);
  assign rad_full  = (hm_q + 44'sd32768) >>> 16;
  assign rad       = $signed(rad_full[27:0]);

  // final rounding, feedforward add and clamp
  assign g_rnd   = (g_q + 62'sd32768) >>> 16;
  assign tm_rnd  = (tm_q + 53'sd8388608) >>> 24;
  assign spd_sum = 47'(ffs_q) + $signed(g_rnd[46:0]);
  assign trn_sum = 33'(fft_q) + $signed(tm_rnd[32:0]);

  always_comb begin
    spd_hit = 1'b0;
    trn_hit = 1'b0;
    spd_sat = $signed(spd_sum[31:0]);
    trn_sat = $signed(trn_sum[31:0]);
    if (spd_sum > 47'sd2147483647) begin
      spd_hit = 1'b1;
      spd_sat = 32'sh7fffffff;
    end else if (spd_sum < -47'sd2147483648) begin
      spd_hit = 1'b1;
      spd_sat = 32'sh80000000;
    end
    if (trn_sum > 33'sd2147483647) begin
      trn_hit = 1'b1;
      trn_sat = 32'sh7fffffff;
    end else if (trn_sum < -33'sd2147483648) begin
      trn_hit = 1'b1;
      trn_sat = 32'sh80000000;
    end
  end

  assign q_pop_o = (state_q == ST_IDLE) && q_avail_i;
  assign out_ld  = (state_q == ST_OUT) && (!out_valid_q || out_if.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_avail_i) state_d = ST_ROT;
      ST_ROT:   if (iter_q == IterW'(RotIters - 1)) state_d = ST_PROJ0;
      ST_PROJ0: state_d = ST_PROJ1;
      ST_PROJ1: state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_OUT;
      ST_OUT:   if (out_ld) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) iter_q <= '0;
      else if (state_q == ST_ROT) iter_q <= iter_q + IterW'(1);
      if (out_ld) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= q_job_i.z0;
      ex_q   <= q_job_i.ex;
      ey_q   <= q_job_i.ey;
      flip_q <= q_job_i.flip;
      herr_q <= q_job_i.herr;
      ffs_q  <= q_job_i.ff_speed;
      fft_q  <= q_job_i.ff_turn;
    end
    if (state_q == ST_ROT) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      // heading path runs beside the rotation
      if (iter_q == IterW'(0)) hm_q <= herr_q * TWO_PI_Q24;
      if (iter_q == IterW'(1)) tm_q <= rad * $signed({1'b0, cfg_i.heading_gain});
    end
    if (state_q == ST_PROJ0) begin
      p_q <= 53'(pc);
      s_q <= s_w;
    end
    if (state_q == ST_PROJ1) p_q <= p_q + pe;
    if (state_q == ST_GAIN)  g_q <= proj * $signed({1'b0, cfg_i.position_gain});
    if (out_ld) begin
      spd_q  <= spd_sat;
      trn_q  <= trn_sat;
      clip_q <= spd_hit || trn_hit;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.speed_command = spd_q;
  assign out_if.turn_command  = trn_q;
  assign out_if.clipped       = clip_q;

`ifndef SYNTHESIS
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == ST_ROT) else $error("pop did not start rotation");
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROT |-> iter_q < IterW'(RotIters)) else $error("iteration overrun");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_ld) |=> state_q == ST_OUT)
    else $error("result dropped while output busy");
  a_ld_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |=> out_valid_q) else $error("loaded result not presented");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Scoreboard: predicts commands for each accepted control tick and checks results in order
class tracking_law_scoreboard;
  typedef struct {
    logic signed [31:0] speed;
    logic signed [31:0] turn;
    logic               clip;
  } command_t;

  logic [23:0] pos_gain;
  logic [23:0] head_gain;
  command_t    pending_q[$];
  int          fail_count;

  function new();
    pos_gain   = utcl_pkg::POS_GAIN_RST;
    head_gain  = utcl_pkg::HEAD_GAIN_RST;
    fail_count = 0;
  endfunction

  function void write_gain(logic [1:0] idx, logic [23:0] val);
    if (idx == utcl_pkg::REG_POSITION_GAIN) pos_gain = val;
    else if (idx == utcl_pkg::REG_HEADING_GAIN) head_gain = val;
  endfunction

  // round half up, arithmetic shift floors
  function longint rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function void rotate(logic [15:0] h, output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit flip;
    longint atan_q[18] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                           20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};
    a = longint'($signed(h));
    flip = 0;
    if (a > 16384 || a < -16384) begin
      a = longint'($signed(16'(a + 32768)));
      flip = 1;
    end
    x = 652032874; y = 0; z = a * 256;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q[i];
      end else begin
        x += dx; y -= dy; z += atan_q[i];
      end
    end
    c = rnd(x, 14);
    s = rnd(y, 14);
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  function longint clamp(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1; return -64'sd2147483648;
    end
    return v;
  endfunction

  function void note_tick(logic signed [31:0] rx, logic signed [31:0] ry, logic [15:0] rh,
                          logic signed [31:0] tx, logic signed [31:0] ty, logic [15:0] th,
                          logic signed [31:0] ffs, logic signed [31:0] fft);
    longint ex, ey, c, s, proj, spd, e, rad, trn;
    bit hit;
    command_t cmd;
    hit = 0;
    ex = longint'(tx) - longint'(rx);
    ey = longint'(ty) - longint'(ry);
    rotate(rh, c, s);
    proj = rnd(ex * c + ey * s, 16);
    spd = clamp(longint'(ffs) + rnd(proj * longint'(pos_gain), 16), hit);
    e = longint'($signed(16'(th - rh)));
    rad = rnd(e * 64'sd105414357, 16);
    trn = clamp(longint'(fft) + rnd(rad * longint'(head_gain), 24), hit);
    cmd.speed = spd[31:0];
    cmd.turn  = trn[31:0];
    cmd.clip  = hit;
    pending_q.push_back(cmd);
  endfunction

  function void check_command(logic signed [31:0] spd, logic signed [31:0] trn, logic clip);
    command_t cmd;
    if (pending_q.size() == 0) begin
      $error("unexpected result: speed_command %0d", spd);
      fail_count++;
      return;
    end
    cmd = pending_q.pop_front();
    if (spd !== cmd.speed) begin
      $error("speed_command: expected %0d, actual %0d", cmd.speed, spd);
      fail_count++;
    end
    if (trn !== cmd.turn) begin
      $error("turn_command: expected %0d, actual %0d", cmd.turn, trn);
      fail_count++;
    end
    if (clip !== cmd.clip) begin
      $error("clipped: expected %0d, actual %0d", cmd.clip, clip);
      fail_count++;
    end
  endfunction
endclass

module testbench;
  import utcl_pkg::*;

  localparam int StallLimit = 20000;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [GainW-1:0]   cfg_wdata_i = '0;
  int                 idle_cycles = 0;
  tracking_law_scoreboard board;

  utcl_in_if  tick_if();
  utcl_out_if cmd_if();

  unicycle_tracking_control_law_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_if(tick_if.sink), .out_if(cmd_if.source)
  );

  always #2 clk_i = ~clk_i;

  // Record accepted ticks and check results at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready)
        board.note_tick(tick_if.robot_x, tick_if.robot_y, tick_if.robot_heading,
                        tick_if.target_x, tick_if.target_y, tick_if.target_heading,
                        tick_if.feedforward_speed, tick_if.feedforward_turn);
      if (cmd_if.valid && cmd_if.ready)
        board.check_command(cmd_if.speed_command, cmd_if.turn_command, cmd_if.clipped);
    end
  end

  // Receiver stalls: alternate free-running and choppy stretches
  always @(posedge clk_i) begin
    int phase;
    phase = int'(($time / 4000) % 3);
    if (phase == 0) cmd_if.ready <= 1'b1;
    else if (phase == 1) cmd_if.ready <= ($urandom_range(0, 3) != 0);
    else cmd_if.ready <= ($urandom_range(0, 9) == 0);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (cmd_if.valid && cmd_if.ready)) idle_cycles <= 0;
    else if (rst_ni && (tick_if.valid || board.pending_q.size() != 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_tick(logic [31:0] rx, logic [31:0] ry, logic [15:0] rh,
                           logic [31:0] tx, logic [31:0] ty, logic [15:0] th,
                           logic [31:0] ffs, logic [31:0] fft);
    tick_if.valid <= 1'b1;
    tick_if.robot_x <= rx; tick_if.robot_y <= ry; tick_if.robot_heading <= rh;
    tick_if.target_x <= tx; tick_if.target_y <= ty; tick_if.target_heading <= th;
    tick_if.feedforward_speed <= ffs; tick_if.feedforward_turn <= fft;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  task automatic send_random_tick();
    logic [31:0] rx, ry;
    rx = pick_word();
    ry = pick_word();
    if ($urandom_range(0, 3) != 0)
      send_tick(rx, ry, 16'($urandom), rx + $urandom_range(0, 400000) - 200000,
                ry + $urandom_range(0, 400000) - 200000, 16'($urandom),
                $urandom_range(0, 600000) - 300000, $urandom_range(0, 600000) - 300000);
    else
      send_tick(rx, ry, 16'($urandom), pick_word(), pick_word(), 16'($urandom),
                pick_word(), pick_word());
  endtask

  task automatic pause_tick();
    tick_if.valid <= 1'b0;
    repeat ($urandom_range(1, 30)) @(posedge clk_i);
  endtask

  // Wait until every result is in, then let the back end drain
  task automatic drain();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_gain(idx, val);
  endtask

  initial begin
    logic [23:0] pos_set[5] = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd3277, 24'd200000};
    logic [23:0] head_set[5] = '{24'd131072, 24'd0, 24'hFFFFFF, 24'd65536, 24'd9000};
    logic [15:0] angles[8] = '{16'h0000, 16'h4000, 16'h4001, 16'h8000, 16'hC000,
                               16'hBFFF, 16'h7FFF, 16'hFFFF};
    board = new();
    tick_if.valid = 0;
    tick_if.robot_x = 0; tick_if.robot_y = 0; tick_if.robot_heading = 0;
    tick_if.target_x = 0; tick_if.target_y = 0; tick_if.target_heading = 0;
    tick_if.feedforward_speed = 0; tick_if.feedforward_turn = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coincident positions, opposite headings, field extremes
    send_tick(0, 0, 0, 0, 0, 0, 0, 0);
    send_tick(32'h12345678, 32'h9ABC0000, 16'h1234, 32'h12345678, 32'h9ABC0000, 16'h9234,
              32'h00010000, 32'hFFFF0000);
    send_tick(32'h80000000, 32'h80000000, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000,
              32'h7FFFFFFF, 32'h7FFFFFFF);
    send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000, 32'h80000000, 32'h80000000, 16'h0000,
              32'h80000000, 32'h80000000);
    foreach (angles[i])
      send_tick(0, 0, angles[i], 32'h00010000, 32'h00010000, ~angles[i], 0, 0);
    send_tick(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
              32'hFFFFFFFF, 32'hFFFFFFFF);
    drain();

    // Random phases across gain settings, sender in bursts
    for (int p = 0; p < 5; p++) begin
      write_gain(REG_POSITION_GAIN, pos_set[p]);
      write_gain(REG_HEADING_GAIN, head_set[p]);
      write_gain(RegUnused, 24'($urandom));
      for (int n = 0; n < 190; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++, n++) send_random_tick();
        if ($urandom_range(0, 2) != 0) pause_tick();
      end
      drain();
    end
    if (board.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
src/utcl_pkg.sv
src/utcl_if.sv
src/utcl_front.sv
src/utcl_fifo.sv
src/utcl_back.sv
src/unicycle_tracking_control_law_top.sv
tb/testbench.sv
